/* design/arp_resolver_table_defines.svh */
// assertion helpers for the address table checks
`ifndef ARP_RESOLVER_TABLE_DEFINES_SVH
`define ARP_RESOLVER_TABLE_DEFINES_SVH

// same-cycle implication, inactive during reset
`define ART_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arp table check failed");

// next-cycle implication, inactive during reset
`define ART_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arp table check failed");

`endif

/* design/art_pkg.sv */
`default_nettype none

package art_pkg;

  // table geometry
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int IP_W            = 32;
  localparam int MAC_W           = 48;
  localparam int ENTRY_W         = IP_W + MAC_W;
  localparam int CFG_W           = 48;

  // arp opcodes, received and emitted
  localparam logic [15:0] OPC_REQUEST = 16'd1;
  localparam logic [15:0] OPC_REPLY   = 16'd2;
  localparam logic [1:0]  OUTOP_NONE    = 2'd0;
  localparam logic [1:0]  OUTOP_REQUEST = 2'd1;
  localparam logic [1:0]  OUTOP_REPLY   = 2'd2;

  localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

  // configuration register indexes
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  // action codes of an input beat
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_ARP    = 1'b1;

  typedef enum logic [2:0] {
    KIND_FORWARD = 3'd0,
    KIND_REQUEST = 3'd1,
    KIND_REPLY   = 3'd2,
    KIND_LEARNED = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ARP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             action;
    logic [IP_W-1:0]  dest_ip;
    logic [15:0]      arp_opcode;
    logic [MAC_W-1:0] sender_mac;
    logic [IP_W-1:0]  sender_ip;
    logic [IP_W-1:0]  target_ip;
  } art_in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [MAC_W-1:0] eth_dest;
    logic [1:0]       out_opcode;
    logic [MAC_W-1:0] out_target_mac;
    logic [IP_W-1:0]  out_target_ip;
  } art_out_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  scan;
    logic  learn;
    logic  set_res;
    kind_t res_kind;
    logic  push;
  } art_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic hit;
    logic miss;
    logic tgt_match;
    logic op_request;
    logic op_reply;
    logic out_free;
  } art_sts_t;

endpackage

`default_nettype wire

/* design/arp_resolver_table.sv */
// arp resolver table: ipv4 to mac address table for an ethernet station
//
// input channel req/req_valid/req_stall carries one packet event per beat:
// an outgoing ip lookup (action 0) or a received arp packet (action 1).
// output channel rsp/rsp_valid/rsp_stall returns exactly one result beat
// per input beat, in order. own_ip and own_mac are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce.
// a lookup scans the table one entry per cycle from a registered ram read;
// a hit stops at the first matching entry, a miss reads every entry. one
// item is in work at a time; the next beat is accepted once the result is
// handed to the output register, so a waiting result beat does not block it.
// reset clears the configuration, empties the table and drops any result.
// a stalled result holds in the output register; a finished item then
// waits until that register frees up, and req_stall stays high meanwhile.
`default_nettype none

`include "arp_resolver_table_defines.svh"

module arp_resolver_table import art_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire art_in_t          req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output art_out_t              rsp,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  art_cmd_t cmd;
  art_sts_t sts;

  // sequencer
  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_action(req.action),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, compare and result registers
  art_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // checks
  `ART_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `ART_ASSERT_SAME(a_no_overwrite, cmd.push, !rsp_valid || !rsp_stall)
  `ART_ASSERT_SAME(a_learn_only_ours, cmd.learn, sts.tgt_match)
  `ART_ASSERT_NEXT(a_push_shows, cmd.push, rsp_valid)

endmodule

`default_nettype wire

/* design/art_ram.sv */
`default_nettype none

module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/art_ctrl.sv */
`default_nettype none

module art_ctrl import art_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_action,
  output logic          req_stall,
  input  wire art_sts_t sts,
  output art_cmd_t      cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    req_stall    = 1'b1;
    cmd          = '0;
    cmd.res_kind = KIND_IGNORED;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = (req_action == ACT_ARP) ? ST_ARP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = KIND_FORWARD;
          state_next   = ST_EMIT;
        end else if (sts.empty || sts.miss) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = KIND_REQUEST;
          state_next   = ST_EMIT;
        end
      end
      ST_ARP: begin
        cmd.set_res = 1'b1;
        state_next  = ST_EMIT;
        if (sts.tgt_match && sts.op_request) begin
          cmd.learn    = 1'b1;
          cmd.res_kind = KIND_REPLY;
        end else if (sts.tgt_match && sts.op_reply) begin
          cmd.learn    = 1'b1;
          cmd.res_kind = KIND_LEARNED;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/art_dp.sv */
`default_nettype none

module art_dp import art_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire art_in_t          req,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire art_cmd_t         cmd,
  output art_sts_t              sts,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output art_out_t              rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [IP_W-1:0]    own_ip;
  logic [MAC_W-1:0]   own_mac;
  art_in_t            item;
  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      rd_idx;
  logic               cmp_vld;
  logic               cmp_last;
  art_out_t           res;
  art_out_t           res_next;
  logic [ENTRY_W-1:0] rd_data;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic               issue;
  logic               wr_en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_IP:  own_ip  <= cfg_data[IP_W-1:0];
        REG_OWN_MAC: own_mac <= cfg_data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= req;
    end
  end

  // table storage, ip in the upper bits
  assign wr_en = cmd.learn && (entry_count < DEPTH_C);

  art_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(entry_count[AW-1:0]),
    .wdata({item.sender_ip, item.sender_mac}),
    .raddr(rd_idx[AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_ip  = rd_data[ENTRY_W-1 -: IP_W];
  assign rd_mac = rd_data[MAC_W-1:0];

  // fill count, saturates at depth
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (wr_en) begin
      entry_count <= CW'(entry_count + CW'(1));
    end
  end

  // scan: one read issued per cycle, compared in the cycle after
  assign issue = cmd.scan && (rd_idx < entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else if (cmd.load) begin
      rd_idx  <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (issue) begin
        rd_idx <= CW'(rd_idx + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_last <= (CW'(rd_idx + CW'(1)) == entry_count);
    end
  end

  // status toward the controller
  always_comb begin
    sts            = '0;
    sts.empty      = (entry_count == '0);
    sts.hit        = cmp_vld && (rd_ip == item.dest_ip);
    sts.miss       = cmp_vld && cmp_last && (rd_ip != item.dest_ip);
    sts.tgt_match  = (item.target_ip == own_ip);
    sts.op_request = (item.arp_opcode == OPC_REQUEST);
    sts.op_reply   = (item.arp_opcode == OPC_REPLY);
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

  // result assembly
  always_comb begin
    res_next      = '0;
    res_next.kind = cmd.res_kind;
    unique case (cmd.res_kind)
      KIND_FORWARD: begin
        res_next.eth_dest = rd_mac;
      end
      KIND_REQUEST: begin
        res_next.eth_dest      = MAC_BCAST;
        res_next.out_opcode    = OUTOP_REQUEST;
        res_next.out_target_ip = item.dest_ip;
      end
      KIND_REPLY: begin
        res_next.eth_dest       = item.sender_mac;
        res_next.out_opcode     = OUTOP_REPLY;
        res_next.out_target_mac = item.sender_mac;
        res_next.out_target_ip  = item.sender_ip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res <= res_next;
    end
  end

  // output register: result beat waits here while a new item runs
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp <= res;
    end
  end

  // own mac is the sender of emitted arp frames, not part of the result
  logic own_mac_unused;
  assign own_mac_unused = ^own_mac;

endmodule

`default_nettype wire

/* bench/arp_resolver_table_tb.sv */
`default_nettype none

module arp_resolver_table_tb import art_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = DEF_TABLE_DEPTH + 8;

  // arp opcodes that must be ignored, including byte-swapped forms
  localparam logic [15:0] OPC_NONE           = 16'h0000;
  localparam logic [15:0] OPC_UNKNOWN        = 16'h0003;
  localparam logic [15:0] OPC_REQUEST_SWAPPED = 16'h0100;
  localparam logic [15:0] OPC_REPLY_SWAPPED  = 16'h0200;
  localparam logic [15:0] OPC_ALL_ONES       = 16'hFFFF;

  localparam logic [IP_W-1:0] STATION_IP_A = 32'hC0A8_0A01;

  // mirror of the address table and the expected result beats
  class arp_answer_board;
    logic [IP_W-1:0]  station_ip;
    logic [MAC_W-1:0] station_mac;
    logic [IP_W-1:0]  ip_tab [DEF_TABLE_DEPTH];
    logic [MAC_W-1:0] mac_tab [DEF_TABLE_DEPTH];
    int unsigned      used;
    art_out_t         answers_due [$];
    int unsigned      errors;
    int unsigned      answers_seen;

    function new();
      station_ip   = '0;
      station_mac  = '0;
      used         = 0;
      errors       = 0;
      answers_seen = 0;
    endfunction

    function void set_station(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      station_ip  = ip;
      station_mac = mac;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // append a sender pair, dropped once the table is full
    function void learn(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      if (used < DEF_TABLE_DEPTH) begin
        ip_tab[used]  = ip;
        mac_tab[used] = mac;
        used++;
      end
    endfunction

    // work out the answer to an accepted packet beat
    function void note_packet(art_in_t p);
      art_out_t r;
      bit       hit;
      r   = '0;
      hit = 1'b0;
      if (p.action == ACT_LOOKUP) begin
        // lowest matching entry wins
        for (int i = 0; i < used; i++) begin
          if (!hit && ip_tab[i] == p.dest_ip) begin
            hit        = 1'b1;
            r.kind     = KIND_FORWARD;
            r.eth_dest = mac_tab[i];
          end
        end
        if (!hit) begin
          r.kind          = KIND_REQUEST;
          r.eth_dest      = MAC_BCAST;
          r.out_opcode    = OUTOP_REQUEST;
          r.out_target_ip = p.dest_ip;
        end
      end else if (p.target_ip == station_ip && p.arp_opcode == OPC_REQUEST) begin
        learn(p.sender_ip, p.sender_mac);
        r.kind           = KIND_REPLY;
        r.eth_dest       = p.sender_mac;
        r.out_opcode     = OUTOP_REPLY;
        r.out_target_mac = p.sender_mac;
        r.out_target_ip  = p.sender_ip;
      end else if (p.target_ip == station_ip && p.arp_opcode == OPC_REPLY) begin
        learn(p.sender_ip, p.sender_mac);
        r.kind = KIND_LEARNED;
      end else begin
        r.kind = KIND_IGNORED;
      end
      answers_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 10)
          $display("result beat %0d, %s: expected %0h, got %0h",
                   answers_seen, name, want, got);
      end
    endfunction

    // compare a result beat with the oldest expected answer
    function void check_answer(art_out_t got);
      art_out_t want;
      answers_seen++;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result beat %0d arrived with nothing expected", answers_seen);
        return;
      end
      want = answers_due.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("eth_dest", 64'(want.eth_dest), 64'(got.eth_dest));
      compare_field("out_opcode", 64'(want.out_opcode), 64'(got.out_opcode));
      compare_field("out_target_mac", 64'(want.out_target_mac),
                    64'(got.out_target_mac));
      compare_field("out_target_ip", 64'(want.out_target_ip),
                    64'(got.out_target_ip));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  art_in_t          req;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  art_out_t         rsp;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  arp_answer_board sb;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  arp_resolver_table u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = RX_HOLD_CYCLES;
    end
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.note_packet(req);
      if (rsp_valid && !rsp_stall)
        sb.check_answer(rsp);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("arp_resolver_table: mismatch");
        $finish;
      end
    end
  end

  // packet beat with every field random
  function automatic art_in_t random_beat();
    art_in_t b;
    b.action     = 1'($urandom);
    b.dest_ip    = $urandom;
    b.arp_opcode = 16'($urandom);
    b.sender_mac = {16'($urandom), $urandom};
    b.sender_ip  = $urandom;
    b.target_ip  = $urandom;
    return b;
  endfunction

  function automatic art_in_t lookup_beat(logic [IP_W-1:0] ip);
    art_in_t b;
    b         = random_beat();
    b.action  = ACT_LOOKUP;
    b.dest_ip = ip;
    return b;
  endfunction

  function automatic art_in_t arp_beat(logic [15:0] op, logic [MAC_W-1:0] smac,
                                       logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
    art_in_t b;
    b            = random_beat();
    b.action     = ACT_ARP;
    b.arp_opcode = op;
    b.sender_mac = smac;
    b.sender_ip  = sip;
    b.target_ip  = tip;
    return b;
  endfunction

  // mostly lookups and arp traffic aimed at us, some noise
  function automatic void pick_packet(output art_in_t b, output bit noise);
    int unsigned     roll;
    logic [IP_W-1:0] known_ip;
    logic [IP_W-1:0] sip;
    logic [15:0]     op;
    roll     = $urandom_range(99);
    known_ip = $urandom;
    if (sb.used > 0)
      known_ip = sb.ip_tab[$urandom_range(sb.used - 1)];
    sip = ($urandom_range(3) == 0) ? known_ip : $urandom;
    op  = ($urandom_range(1) == 0) ? OPC_REQUEST : OPC_REPLY;
    if (roll < 30)
      b = lookup_beat(known_ip);
    else if (roll < 45)
      b = lookup_beat($urandom);
    else if (roll < 80)
      b = arp_beat(op, {16'($urandom), $urandom}, sip, sb.station_ip);
    else if (roll < 87)
      b = arp_beat(op, {16'($urandom), $urandom}, sip,
                   sb.station_ip ^ (32'h1 << $urandom_range(31)));
    else if (roll < 94)
      b = arp_beat(16'($urandom), {16'($urandom), $urandom}, sip, sb.station_ip);
    else
      b = random_beat();
    noise = b.action == ACT_ARP && !(b.target_ip == sb.station_ip &&
            (b.arp_opcode == OPC_REQUEST || b.arp_opcode == OPC_REPLY));
  endfunction

  // offer one beat, with random gaps before it
  task automatic send_beat(input art_in_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= b;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // stop offering and wait for every answer
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_station(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_IP;
    cfg_data  <= CFG_W'(ip);
    @(posedge clk);
    cfg_index <= REG_OWN_MAC;
    cfg_data  <= mac;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_station(ip, mac);
  endtask

  // random traffic until enough beats that the block acts on
  task automatic run_traffic(input int src_pct, input int sink_pct, input int beats);
    art_in_t b;
    bit      noise;
    int      counted;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    counted       = 0;
    while (counted < beats) begin
      pick_packet(b, noise);
      send_beat(b);
      if (!noise)
        counted++;
    end
  endtask

  initial begin
    sb        = new();
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_OWN_IP;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    set_station(STATION_IP_A, {16'($urandom), $urandom});

    // directed: empty table, learning, duplicates, ignored packets
    send_beat(lookup_beat('0));
    send_beat(lookup_beat('1));
    send_beat(arp_beat(OPC_REQUEST, '1, '1, STATION_IP_A));
    send_beat(arp_beat(OPC_REPLY, '0, '0, STATION_IP_A));
    send_beat(lookup_beat('1));
    send_beat(lookup_beat('0));
    send_beat(arp_beat(OPC_REQUEST, 48'h0200_0000_0001, '1, STATION_IP_A));
    send_beat(lookup_beat('1));
    send_beat(arp_beat(OPC_NONE, 48'h0200_0000_0002, 32'h0A00_0002, STATION_IP_A));
    send_beat(arp_beat(OPC_UNKNOWN, 48'h0200_0000_0003, 32'h0A00_0003, STATION_IP_A));
    send_beat(arp_beat(OPC_ALL_ONES, 48'h0200_0000_0004, 32'h0A00_0004, STATION_IP_A));
    send_beat(arp_beat(OPC_REQUEST_SWAPPED, 48'h0200_0000_0005, 32'h0A00_0005,
                       STATION_IP_A));
    send_beat(arp_beat(OPC_REPLY_SWAPPED, 48'h0200_0000_0006, 32'h0A00_0006,
                       STATION_IP_A));
    send_beat(arp_beat(OPC_REQUEST, 48'h0200_0000_0007, 32'h0A00_0007,
                       STATION_IP_A ^ 32'h1));
    send_beat(arp_beat(OPC_REPLY, 48'h0200_0000_0008, 32'h0A00_0008, '0));
    send_beat(lookup_beat(32'h0A00_0002));
    send_beat(lookup_beat(STATION_IP_A));
    send_beat(arp_beat(OPC_REPLY, 48'h0200_0000_0009, 32'h0A00_0009, STATION_IP_A));
    send_beat(lookup_beat(32'h0A00_0009));

    // phase one: sender idles less than receiver
    run_traffic(28, 84, 120);
    settle();
    set_station('1, '1);

    // phase two: the other way round
    run_traffic(84, 28, 120);
    settle();
    set_station('0, '0);

    // phase three: no idling, with a long receiver hold and a sender pause
    run_traffic(0, 0, 24);
    hold_reqs++;
    run_traffic(0, 0, 48);
    settle();
    run_traffic(0, 0, 48);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("arp_resolver_table: match");
    else
      $display("arp_resolver_table: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
